### design/utf8d_pkg.sv
// Shared types, constants and decode helpers for the UTF-8 to UTF-16 decoder.
package utf8d_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_LEAD  = 3'd1;
    localparam logic [2:0] ST_BAD_CONT  = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;

    localparam logic [31:0] MAX_SCALAR  = 32'h0010_FFFF;
    localparam logic [10:0] PAIR_BIAS   = 11'h040;
    localparam logic [5:0]  HIGH_PREFIX = 6'b110110;
    localparam logic [5:0]  LOW_PREFIX  = 6'b110111;

    typedef enum logic [1:0] {
        EV_CHAR,
        EV_PAIR,
        EV_ERROR
    } ev_kind_t;

    // One classified event per decoded character or error: a single unit, a surrogate pair or an error.
    typedef struct packed {
        ev_kind_t    kind;
        logic [20:0] value;
        logic [2:0]  status;
        logic [31:0] offset;
    } ev_t;

    function automatic logic [2:0] trail_of(input logic [7:0] b);
        logic [2:0] t;
        if (b < 8'hC0)
            t = 3'd0;
        else if (b < 8'hE0)
            t = 3'd1;
        else if (b < 8'hF0)
            t = 3'd2;
        else if (b < 8'hF8)
            t = 3'd3;
        else if (b < 8'hFC)
            t = 3'd4;
        else
            t = 3'd5;
        return t;
    endfunction

    function automatic logic [31:0] seq_offset(input logic [2:0] t);
        logic [31:0] off;
        case (t)
            3'd1:    off = 32'h0000_3080;
            3'd2:    off = 32'h000E_2080;
            3'd3:    off = 32'h03C8_2080;
            3'd4:    off = 32'hFA08_2080;
            3'd5:    off = 32'h8208_2080;
            default: off = 32'h0000_0000;
        endcase
        return off;
    endfunction

endpackage

### design/utf8d_front.sv
// Front end: sequence tracking, byte counting and event classification.
module utf8d_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 q_full,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_stream,
    output logic                 ev_valid,
    output utf8d_pkg::ev_t       ev
);

    logic [31:0] acc_reg, acc_next;
    logic [2:0]  rem_reg, rem_next;
    logic [2:0]  trail_reg, trail_next;
    logic [31:0] pos_reg, pos_next;

    logic        accept;
    logic [2:0]  lead_trail;
    logic [31:0] acc_shift;
    logic [31:0] value;
    logic [31:0] pos_inc;

    assign accept     = push && !q_full;
    assign lead_trail = utf8d_pkg::trail_of(data_byte);
    assign acc_shift  = {acc_reg[25:0], 6'b0} + {24'b0, data_byte};
    assign value      = acc_shift - utf8d_pkg::seq_offset(trail_reg);
    assign pos_inc    = pos_reg + 32'd1;

    always_comb
    begin
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        trail_next = trail_reg;
        pos_next   = pos_reg;
        ev_valid   = 1'b0;
        ev.kind    = utf8d_pkg::EV_CHAR;
        ev.value   = {13'b0, data_byte};
        ev.status  = utf8d_pkg::ST_OK;
        ev.offset  = pos_reg;

        if (rem_reg == 3'd0)
        begin
            if (!data_byte[7])
            begin
                ev_valid = 1'b1;
            end
            else if (data_byte < 8'hC0 || data_byte >= 8'hFE)
            begin
                ev_valid  = 1'b1;
                ev.kind   = utf8d_pkg::EV_ERROR;
                ev.status = utf8d_pkg::ST_BAD_LEAD;
            end
            else
            begin
                acc_next   = {24'b0, data_byte};
                rem_next   = lead_trail;
                trail_next = lead_trail;
            end
        end
        else if (data_byte[7:6] != 2'b10)
        begin
            // Drop the partial sequence together with the offending byte.
            ev_valid   = 1'b1;
            ev.kind    = utf8d_pkg::EV_ERROR;
            ev.status  = utf8d_pkg::ST_BAD_CONT;
            acc_next   = 32'b0;
            rem_next   = 3'd0;
            trail_next = 3'd0;
        end
        else
        begin
            acc_next = acc_shift;
            rem_next = rem_reg - 3'd1;
            if (rem_reg == 3'd1)
            begin
                ev_valid   = 1'b1;
                ev.value   = value[20:0];
                acc_next   = 32'b0;
                trail_next = 3'd0;
                if (value[31:16] == 16'b0)
                begin
                    ev.kind = utf8d_pkg::EV_CHAR;
                end
                else if (value > utf8d_pkg::MAX_SCALAR)
                begin
                    ev.kind   = utf8d_pkg::EV_ERROR;
                    ev.status = utf8d_pkg::ST_TOO_LARGE;
                    ev.offset = pos_inc;
                end
                else
                begin
                    ev.kind = utf8d_pkg::EV_PAIR;
                end
            end
        end

        if (end_of_stream)
        begin
            // An open sequence here never coincides with another event.
            if (rem_next != 3'd0)
            begin
                ev_valid  = 1'b1;
                ev.kind   = utf8d_pkg::EV_ERROR;
                ev.status = utf8d_pkg::ST_TRUNCATED;
                ev.offset = pos_reg;
            end
            acc_next   = 32'b0;
            rem_next   = 3'd0;
            trail_next = 3'd0;
            pos_next   = 32'b0;
        end
        else
        begin
            pos_next = pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= 32'b0;
            rem_reg   <= 3'd0;
            trail_reg <= 3'd0;
            pos_reg   <= 32'b0;
        end
        else if (accept)
        begin
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            trail_reg <= trail_next;
            pos_reg   <= pos_next;
        end
    end

`ifndef SYNTH
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= 3'd5)
        else $error("remaining count out of range");

    a_trail_covers_rem: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg != 3'd0 |-> trail_reg >= rem_reg)
        else $error("open sequence without a matching length");
`endif

endmodule

### design/utf8d_queue.sv
// Short event queue between the front end and the result expander.
module utf8d_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  utf8d_pkg::ev_t       wr_ev,
    input  logic                 rd_en,
    output utf8d_pkg::ev_t       head,
    output logic                 q_empty,
    output logic                 q_full
);

    utf8d_pkg::ev_t entry_reg [utf8d_pkg::QUEUE_DEPTH];

    logic [utf8d_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [utf8d_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [utf8d_pkg::QUEUE_CW-1:0] count_reg, count_next;

    logic do_wr;
    logic do_rd;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == utf8d_pkg::QUEUE_CW'(utf8d_pkg::QUEUE_DEPTH));
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= utf8d_pkg::QUEUE_CW'(utf8d_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != utf8d_pkg::QUEUE_CW'(utf8d_pkg::QUEUE_DEPTH)) |->
        (utf8d_pkg::QUEUE_AW'(wr_ptr_reg - rd_ptr_reg) ==
         utf8d_pkg::QUEUE_AW'(count_reg)))
        else $error("queue pointers disagree with count");
`endif

endmodule

### design/utf8d_back.sv
// Back end: expands queued events into UTF-16 result words.
module utf8d_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  utf8d_pkg::ev_t       head,
    input  logic                 q_empty,
    input  logic                 pop,
    output logic                 rd_en,
    output logic [15:0]          code_unit,
    output logic [2:0]           status,
    output logic [31:0]          error_offset,
    output logic                 last
);

    logic        second_reg, second_next;
    logic        take;
    logic [10:0] high_bits;

    assign take      = pop && !q_empty;
    assign high_bits = head.value[20:10] - utf8d_pkg::PAIR_BIAS;

    always_comb
    begin
        second_next  = second_reg;
        rd_en        = 1'b0;
        code_unit    = 16'b0;
        status       = head.status;
        error_offset = 32'b0;
        last         = 1'b1;

        case (head.kind)
            utf8d_pkg::EV_CHAR:
            begin
                code_unit = head.value[15:0];
            end
            utf8d_pkg::EV_PAIR:
            begin
                if (second_reg)
                begin
                    code_unit = {utf8d_pkg::LOW_PREFIX, head.value[9:0]};
                end
                else
                begin
                    code_unit = {utf8d_pkg::HIGH_PREFIX, high_bits[9:0]};
                    last      = 1'b0;
                end
            end
            utf8d_pkg::EV_ERROR:
            begin
                error_offset = head.offset;
            end
            default:
            begin
                code_unit = 16'b0;
            end
        endcase

        if (take)
        begin
            // Hold the pair entry until its low half has gone out.
            if (head.kind == utf8d_pkg::EV_PAIR && !second_reg)
            begin
                second_next = 1'b1;
            end
            else
            begin
                second_next = 1'b0;
                rd_en       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            second_reg <= 1'b0;
        else
            second_reg <= second_next;
    end

`ifndef SYNTH
    a_second_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> (!q_empty && head.kind == utf8d_pkg::EV_PAIR))
        else $error("low half pending without a pair at the head");
`endif

endmodule

### design/utf8_to_utf16_stream_decoder_core.sv
// Top level of the UTF-8 to UTF-16 stream decoder.
//
//   channel  direction  handshake            words
//   bytes    in         push / full          data_byte, end_of_stream
//   units    out        pop / empty          code_unit, status, error_offset, last
//
// One byte is taken per cycle while the four-entry event queue has room.
// A byte's event is registered in the event queue and reaches the result ports from its head.
// A surrogate pair occupies one queue entry and leaves as two words on two pops.
// A stall on the result side fills the queue, then raises full.
// Reset clears the sequence state, byte counter and queue at once.
module utf8_to_utf16_stream_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] code_unit,
    output logic [2:0]  status,
    output logic [31:0] error_offset,
    output logic        last
);

    utf8d_pkg::ev_t ev;
    utf8d_pkg::ev_t head;
    logic           ev_valid;
    logic           q_full;
    logic           q_empty;
    logic           rd_en;

    assign full  = q_full;
    assign empty = q_empty;

    utf8d_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .q_full        (q_full),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .ev_valid      (ev_valid),
        .ev            (ev)
    );

    utf8d_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ev_valid && push && !q_full),
        .wr_ev   (ev),
        .rd_en   (rd_en),
        .head    (head),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    utf8d_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .rd_en        (rd_en),
        .code_unit    (code_unit),
        .status       (status),
        .error_offset (error_offset),
        .last         (last)
    );

endmodule

### tb/utf8_to_utf16_stream_decoder_core_test.sv
// Self-checking testbench for the UTF-8 to UTF-16 stream decoder core.
module utf8_to_utf16_stream_decoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [2:0]  status;
        logic [31:0] error_offset;
        logic        last;
    } unit_word_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        end_of_stream;
    logic        empty;
    logic        pop;
    logic [15:0] code_unit;
    logic [2:0]  status;
    logic [31:0] error_offset;
    logic        last;

    // decoder state as the testbench sees it
    logic [31:0] seq_acc;
    logic [2:0]  seq_left;
    logic [2:0]  seq_len;
    logic [31:0] stream_pos;

    unit_word_t  expected_words[$];
    int          mismatch_count;
    bit          tx_idle;
    bit          rx_idle;
    int          rx_hold_cycles;

    utf8_to_utf16_stream_decoder_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .empty         (empty),
        .pop           (pop),
        .code_unit     (code_unit),
        .status        (status),
        .error_offset  (error_offset),
        .last          (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // number of continuation bytes a lead byte announces; 0 for an illegal lead
    function automatic logic [2:0] lead_trail(input logic [7:0] b);
        logic [2:0] t;
        if (b[7:5] == 3'b110)
            t = 3'd1;
        else if (b[7:4] == 4'b1110)
            t = 3'd2;
        else if (b[7:3] == 5'b11110)
            t = 3'd3;
        else if (b[7:2] == 6'b111110)
            t = 3'd4;
        else if (b[7:1] == 7'b1111110)
            t = 3'd5;
        else
            t = 3'd0;
        return t;
    endfunction

    // bias that removes the length marker bits folded into the accumulator
    function automatic logic [31:0] len_bias(input logic [2:0] t);
        case (t)
            3'd1:    return 32'h0000_3080;
            3'd2:    return 32'h000E_2080;
            3'd3:    return 32'h03C8_2080;
            3'd4:    return 32'hFA08_2080;
            3'd5:    return 32'h8208_2080;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic unit_word_t make_word(input logic [15:0] unit, input logic [2:0] st,
                                             input logic [31:0] off);
        unit_word_t w;
        w.code_unit    = unit;
        w.status       = st;
        w.error_offset = off;
        w.last         = 1'b0;
        return w;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic eos);
        unit_word_t  res [2];
        unit_word_t  w;
        int          n;
        logic [31:0] v;
        logic [31:0] pos;
        n   = 0;
        pos = stream_pos;
        if (seq_left == 3'd0)
        begin
            if (b[7] == 1'b0)
            begin
                res[n] = make_word({8'h00, b}, utf8d_pkg::ST_OK, 32'd0);
                n++;
            end
            else if (lead_trail(b) == 3'd0)
            begin
                res[n] = make_word(16'h0000, utf8d_pkg::ST_BAD_LEAD, pos);
                n++;
            end
            else
            begin
                seq_acc  = {24'h0, b};
                seq_left = lead_trail(b);
                seq_len  = seq_left;
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            // drop the partial sequence along with the offending byte
            res[n] = make_word(16'h0000, utf8d_pkg::ST_BAD_CONT, pos);
            n++;
            seq_acc  = 32'd0;
            seq_left = 3'd0;
            seq_len  = 3'd0;
        end
        else
        begin
            seq_acc  = (seq_acc << 6) + {24'h0, b};
            seq_left = seq_left - 3'd1;
            if (seq_left == 3'd0)
            begin
                v = seq_acc - len_bias(seq_len);
                if (v[31:16] == 16'h0000)
                begin
                    res[n] = make_word(v[15:0], utf8d_pkg::ST_OK, 32'd0);
                    n++;
                end
                else if (v > utf8d_pkg::MAX_SCALAR)
                begin
                    res[n] = make_word(16'h0000, utf8d_pkg::ST_TOO_LARGE, pos + 32'd1);
                    n++;
                end
                else
                begin
                    v = v - 32'h0001_0000;
                    res[n] = make_word({6'd0, v[19:10]} + 16'hD800, utf8d_pkg::ST_OK,
                                       32'd0);
                    n++;
                    res[n] = make_word({6'd0, v[9:0]} + 16'hDC00, utf8d_pkg::ST_OK, 32'd0);
                    n++;
                end
                seq_acc = 32'd0;
                seq_len = 3'd0;
            end
        end
        if (eos)
        begin
            if (seq_left != 3'd0)
            begin
                res[n] = make_word(16'h0000, utf8d_pkg::ST_TRUNCATED, pos);
                n++;
            end
            seq_acc    = 32'd0;
            seq_left   = 3'd0;
            seq_len    = 3'd0;
            stream_pos = 32'd0;
        end
        else
        begin
            stream_pos = pos + 32'd1;
        end
        for (int i = 0; i < n; i++)
        begin
            w      = res[i];
            w.last = (i == n - 1);
            expected_words.push_back(w);
        end
    endtask

    // entered and left at a falling edge; push stays high for a back-to-back word
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push          <= 1'b1;
        data_byte     <= b;
        end_of_stream <= eos;
        do
            @(posedge clk);
        while (full);
        decode_byte(b, eos);
        @(negedge clk);
    endtask

    task automatic send_stream_byte(input logic [7:0] b, inout int sent);
        send_byte(b, $urandom_range(0, 63) == 0);
        sent++;
    endtask

    // mostly well-formed sequences with random payload; some noise and cut-short ones
    task automatic send_random_sequence(inout int sent);
        int          pick;
        int          len;
        int          cut;
        logic [7:0]  lead;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            send_stream_byte(8'($urandom_range(0, 127)), sent);
            return;
        end
        if (pick < 45)
        begin
            send_stream_byte(8'($urandom_range(0, 255)), sent);
            return;
        end
        if (pick < 63)
        begin
            len  = 2;
            lead = 8'hC0 | 8'($urandom_range(0, 31));
        end
        else if (pick < 77)
        begin
            len  = 3;
            lead = 8'hE0 | 8'($urandom_range(0, 15));
        end
        else if (pick < 89)
        begin
            len  = 4;
            lead = 8'hF0 + 8'($urandom_range(0, 4));
        end
        else if (pick < 94)
        begin
            len  = 5;
            lead = 8'hF8 | 8'($urandom_range(0, 3));
        end
        else
        begin
            len  = 6;
            lead = 8'hFC | 8'($urandom_range(0, 1));
        end
        cut = len;
        if ($urandom_range(0, 9) == 0)
            cut = $urandom_range(1, len - 1);
        send_stream_byte(lead, sent);
        for (int i = 1; i < cut; i++)
            send_stream_byte(8'h80 | 8'($urandom_range(0, 63)), sent);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic test_single_units();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    task automatic test_long_forms();
        // highest scalar as a surrogate pair
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // six-byte overlong zero passes through unchecked
        send_byte(8'hFC, 1'b0);
        repeat (5) send_byte(8'h80, 1'b0);
    endtask

    task automatic test_range_errors();
        send_byte(8'hF4, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    task automatic test_bad_bytes();
        send_byte(8'h80, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_truncation();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
    endtask

    task automatic test_output_stall();
        int sent;
        sent           = 0;
        tx_idle        = 1'b0;
        rx_idle        = 1'b0;
        rx_hold_cycles = 120;
        while (sent < 50)
            send_random_sequence(sent);
    endtask

    task automatic test_drain_pause();
        int sent;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (3)
        begin
            sent = 0;
            while (sent < 20)
                send_random_sequence(sent);
            wait_drained();
        end
    endtask

    task automatic test_random_streams(input int target);
        int sent;
        int mark;
        sent = 0;
        mark = 0;
        while (sent < target)
        begin
            if (sent >= mark)
            begin
                tx_idle = 1'($urandom_range(0, 1));
                rx_idle = 1'($urandom_range(0, 1));
                mark    = sent + 150;
            end
            send_random_sequence(sent);
        end
    endtask

    task automatic check_unit_word();
        unit_word_t exp_word;
        if (expected_words.size() == 0)
        begin
            $error("unexpected word: code_unit %h status %0d error_offset %0d last %0b",
                   code_unit, status, error_offset, last);
            mismatch_count++;
        end
        else
        begin
            exp_word = expected_words.pop_front();
            if (code_unit !== exp_word.code_unit)
            begin
                $error("code_unit: expected %h, got %h", exp_word.code_unit, code_unit);
                mismatch_count++;
            end
            if (status !== exp_word.status)
            begin
                $error("status: expected %0d, got %0d", exp_word.status, status);
                mismatch_count++;
            end
            if (error_offset !== exp_word.error_offset)
            begin
                $error("error_offset: expected %0d, got %0d", exp_word.error_offset,
                       error_offset);
                mismatch_count++;
            end
            if (last !== exp_word.last)
            begin
                $error("last: expected %0b, got %0b", exp_word.last, last);
                mismatch_count++;
            end
        end
    endtask

    // result side: random stalls, plus a long hold-off when a test asks for one
    initial
    begin : unit_sink
        int stall;
        pop = 1'b0;
        while (rst_n !== 1'b1)
            @(negedge clk);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 14) : 0;
            if (rx_hold_cycles > 0)
            begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            check_unit_word();
            @(negedge clk);
        end
    end

    initial
    begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        push           = 1'b0;
        data_byte      = 8'h00;
        end_of_stream  = 1'b0;
        seq_acc        = 32'd0;
        seq_left       = 3'd0;
        seq_len        = 3'd0;
        stream_pos     = 32'd0;
        mismatch_count = 0;
        tx_idle        = 1'b1;
        rx_idle        = 1'b1;
        rx_hold_cycles = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_single_units();
        test_long_forms();
        test_range_errors();
        test_bad_bytes();
        test_truncation();
        test_output_stall();
        test_drain_pause();
        test_random_streams(1400);

        // drain, then leave room for any stray word
        wait_drained();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
design/utf8d_pkg.sv
design/utf8d_front.sv
design/utf8d_queue.sv
design/utf8d_back.sv
design/utf8_to_utf16_stream_decoder_core.sv
tb/utf8_to_utf16_stream_decoder_core_test.sv
